### design/ddd_pkg.sv
`timescale 1ns / 1ps

package ddd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 22;

  localparam int unsigned MAX_YEAR   = 9999;
  localparam int unsigned DAYS_NORMAL_YEAR = 365;
  localparam int unsigned COUNT_MAX  = 4194303;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 43699
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned MUL_CONST_W = 13;
  localparam int unsigned PROD_W      = YEAR_W + MUL_CONST_W;

  localparam int unsigned Q100_W  = 7;
  localparam int unsigned Q400_W  = 5;
  localparam int unsigned CORR_W  = 12;
  localparam int unsigned START_W = 9;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUM  = 5'b00100,
    S_DIFF = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  // multiplier passes, one product per cycle
  typedef enum logic [1:0] {
    M_YEAR_Q100 = 2'd0,
    M_PREV_Q100 = 2'd1,
    M_PREV_Q400 = 2'd2,
    M_BASE      = 2'd3
  } mul_step_t;

  // days before the first of month m (1..12)
  function automatic logic [START_W-1:0] month_start(input logic leap, input month_t m);
    logic [START_W-1:0] s;
    unique case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

### design/date_difference_days_top.sv
`timescale 1ns / 1ps

// channel  | ports                                        | direction
// ---------+----------------------------------------------+----------
// input    | in_valid, in_stall, in_first_*, in_second_*  | in
// result   | out_valid, out_stall, out_day_count          | out
//
// from accept to out_valid, each date makes four passes through
// one shared 14x13 constant multiplier and then a sum step; a difference step ends the item
// reset clears the sequencer and out_valid; in_stall is high from accept until the
// result has been taken, so one item is in flight at a time
// out_stall holds the result in the output register as long as it is high

module date_difference_days_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ddd_pkg::year_t         in_first_year,
  input  ddd_pkg::month_t        in_first_month,
  input  ddd_pkg::day_t          in_first_day,
  input  ddd_pkg::year_t         in_second_year,
  input  ddd_pkg::month_t        in_second_month,
  input  ddd_pkg::day_t          in_second_day,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ddd_pkg::count_t        out_day_count
);
  import ddd_pkg::*;

  state_t    state_r, state_nxt;
  mul_step_t step_r, step_nxt;
  logic      sel_r, sel_nxt;

  year_t  year_r  [2];
  month_t month_r [2];
  day_t   day_r   [2];

  logic [Q100_W-1:0] qy100_r, qp100_r;
  logic [Q400_W-1:0] qp400_r;
  count_t            base_r;
  count_t            dn_a_r, dn_b_r;
  count_t            count_r;

  year_t              cur_year, cur_prev, mul_a;
  month_t             cur_month;
  day_t               cur_day;
  logic [MUL_CONST_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic               leap, div4, div100;
  logic [CORR_W-1:0]  corr;
  count_t             dn_sum;
  count_t             diff;

  function automatic year_t clamp_year(input year_t y);
    return (y > YEAR_W'(MAX_YEAR)) ? YEAR_W'(MAX_YEAR) : y;
  endfunction

  function automatic month_t clamp_month(input month_t m);
    month_t r;
    r = m;
    if (m == 4'd0) begin
      r = 4'd1;
    end else if (m > 4'd12) begin
      r = 4'd12;
    end
    return r;
  endfunction

  assign cur_year  = sel_r ? year_r[1]  : year_r[0];
  assign cur_month = sel_r ? month_r[1] : month_r[0];
  assign cur_day   = sel_r ? day_r[1]   : day_r[0];
  assign cur_prev  = cur_year - YEAR_W'(1);

  // shared multiplier: operand and constant chosen by the pass
  always_comb begin
    unique case (step_r)
      M_YEAR_Q100: begin mul_a = cur_year;              mul_b = MUL_CONST_W'(RECIP_100); end
      M_PREV_Q100: begin mul_a = cur_prev;              mul_b = MUL_CONST_W'(RECIP_100); end
      M_PREV_Q400: begin mul_a = {2'b00, cur_prev[YEAR_W-1:2]};
                         mul_b = MUL_CONST_W'(RECIP_100); end
      M_BASE:      begin mul_a = cur_year;              mul_b = MUL_CONST_W'(DAYS_NORMAL_YEAR); end
      default:     begin mul_a = cur_year;              mul_b = MUL_CONST_W'(RECIP_100); end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // leap: divisible by 4, and either not by 100 or by 400
  assign div4   = (cur_year[1:0] == 2'b00);
  assign div100 = ((YEAR_W'(qy100_r) * YEAR_W'(100)) == cur_year);
  assign leap   = div4 && (!div100 || (qy100_r[1:0] == 2'b00));

  // leap days before the year, year zero counted as a leap year
  assign corr = (cur_year == '0) ? '0 :
                CORR_W'(1) + CORR_W'(cur_prev[YEAR_W-1:2]) + CORR_W'(qp400_r)
                - CORR_W'(qp100_r);

  assign dn_sum = base_r + COUNT_W'(corr) + COUNT_W'(month_start(leap, cur_month))
                  + COUNT_W'(cur_day);

  always_comb begin
    count_t d;
    d    = (dn_a_r > dn_b_r) ? (dn_a_r - dn_b_r) : (dn_b_r - dn_a_r);
    diff = (d > COUNT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : d;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MUL;
          step_nxt  = M_YEAR_Q100;
          sel_nxt   = 1'b0;
        end
      end
      S_MUL: begin
        if (step_r == M_BASE) begin
          state_nxt = S_SUM;
        end else begin
          step_nxt = mul_step_t'(step_r + 2'd1);
        end
      end
      S_SUM: begin
        if (sel_r) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_MUL;
          step_nxt  = M_YEAR_Q100;
          sel_nxt   = 1'b1;
        end
      end
      S_DIFF: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= M_YEAR_Q100;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      year_r[0]  <= clamp_year(in_first_year);
      month_r[0] <= clamp_month(in_first_month);
      day_r[0]   <= in_first_day;
      year_r[1]  <= clamp_year(in_second_year);
      month_r[1] <= clamp_month(in_second_month);
      day_r[1]   <= in_second_day;
    end
    if (state_r == S_MUL) begin
      unique case (step_r)
        M_YEAR_Q100: qy100_r <= prod[RECIP_SHIFT +: Q100_W];
        M_PREV_Q100: qp100_r <= prod[RECIP_SHIFT +: Q100_W];
        M_PREV_Q400: qp400_r <= prod[RECIP_SHIFT +: Q400_W];
        M_BASE:      base_r  <= prod[COUNT_W-1:0];
        default:     base_r  <= prod[COUNT_W-1:0];
      endcase
    end
    if (state_r == S_SUM) begin
      if (sel_r) begin
        dn_b_r <= dn_sum;
      end else begin
        dn_a_r <= dn_sum;
      end
    end
    if (state_r == S_DIFF) begin
      count_r <= diff;
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign out_day_count = count_r;

endmodule

### design/ddd_checker.sv
`timescale 1ns / 1ps

module ddd_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input ddd_pkg::count_t        out_day_count
);
  import ddd_pkg::*;

  // one item in flight: busy after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("input taken while an item is in flight");

  a_result_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result shown while input side is open");

  // widest span: year zero, day zero against the last day of the top year
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day_count <= COUNT_W'(3652425)))
    else $error("day count beyond the calendar span");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_day_count)))
    else $error("stalled result changed");

endmodule

bind date_difference_days_top ddd_checker u_ddd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_day_count (out_day_count)
);
